@@ hw/rtl/mh_pkg.sv @@
// ----------------------------------------------------------------------------
// mh_pkg
// Shared constants, types and helper functions for the MurmurHash64A stream
// hash core: mix constant, queue sizing, item classification and states.
// ----------------------------------------------------------------------------
package mh_pkg;

  // mix multiplier and xor-shift distance
  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int          MIX_SHIFT  = 47;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what the back end does with an item
  typedef enum logic [1:0] {
    OP_FULL,   // full 8-byte word mix
    OP_TAIL,   // 1..7 byte tail xor and one multiply
    OP_FIN     // last word with no bytes, finalize only
  } op_t;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  tail_bytes;
    op_t         kind;
    logic        first;
    logic        last;
    logic [31:0] seed;
    logic [31:0] len;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_DISP,
    BS_LEN,
    BS_KEY1,
    BS_KEY2,
    BS_HASH,
    BS_FIN,
    BS_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_CROSS_A,
    MP_CROSS_B
  } mul_phase_t;

  function automatic logic [63:0] xs47(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

  // keep the low n bytes of a word
  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/mh_stream_if.sv @@
// ----------------------------------------------------------------------------
// mh_stream_if
// Valid/ready channels of the hash core: message words in, hash values out.
// ----------------------------------------------------------------------------
interface mh_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic [31:0] seed;
  logic [31:0] total_length;

  modport source (output valid, data_word, byte_count, last, seed, total_length,
                  input ready);
  modport sink (input valid, data_word, byte_count, last, seed, total_length,
                output ready);
endinterface

interface mh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

@@ hw/rtl/mh_front.sv @@
// ----------------------------------------------------------------------------
// mh_front
// Accepts message words, tracks message boundaries and classifies each word
// into a full mix, a tail or a finalize-only step for the back end.
// ----------------------------------------------------------------------------
module mh_front
  import mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mh_msg_if.sink      msg,
  input  logic        q_full,
  output push_t       push
);

  logic in_message;
  logic accept;

  assign msg.ready = !q_full;
  assign accept    = msg.valid && msg.ready;

  // classify the word
  always_comb begin
    push.valid           = accept;
    push.item.word       = msg.data_word;
    push.item.tail_bytes = msg.byte_count[2:0];
    push.item.first      = !in_message;
    push.item.last       = msg.last;
    push.item.seed       = msg.seed;
    push.item.len        = msg.total_length;
    if (!msg.last || msg.byte_count[3]) begin
      push.item.kind = OP_FULL;
    end else if (msg.byte_count[2:0] != 3'd0) begin
      push.item.kind = OP_TAIL;
    end else begin
      push.item.kind = OP_FIN;
    end
  end

  // message boundary tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (accept) begin
      in_message <= !msg.last;
    end
  end

endmodule

@@ hw/rtl/mh_queue.sv @@
// ----------------------------------------------------------------------------
// mh_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module mh_queue
  import mh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mh_mul64.sv @@
// ----------------------------------------------------------------------------
// mh_mul64
// Low 64 bits of a times the mix multiplier, built from three 32x32 partial
// products on one shared multiplier, one partial product per cycle.
// ----------------------------------------------------------------------------
module mh_mul64
  import mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic        done,
  output logic [63:0] result
);

  mul_phase_t  phase;
  mul_phase_t  phase_next;
  logic [63:0] a_reg;
  logic [63:0] acc;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;
  logic [63:0] addend;

  assign result = acc;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      MP_IDLE:    phase_next = MP_IDLE;
      MP_LO:      phase_next = MP_CROSS_A;
      MP_CROSS_A: phase_next = MP_CROSS_B;
      MP_CROSS_B: phase_next = MP_IDLE;
      default:    phase_next = MP_IDLE;
    endcase
    if (start) begin
      phase_next = MP_LO;
    end
  end

  // operand selection per phase
  always_comb begin
    op_x = a_reg[31:0];
    op_y = MIX_MUL_LO;
    unique case (phase)
      MP_IDLE:    begin op_x = a_reg[31:0];  op_y = MIX_MUL_LO; end
      MP_LO:      begin op_x = a_reg[31:0];  op_y = MIX_MUL_LO; end
      MP_CROSS_A: begin op_x = a_reg[31:0];  op_y = MIX_MUL_HI; end
      MP_CROSS_B: begin op_x = a_reg[63:32]; op_y = MIX_MUL_LO; end
      default:    begin op_x = a_reg[31:0];  op_y = MIX_MUL_LO; end
    endcase
  end

  assign prod   = 64'(op_x) * 64'(op_y);
  assign addend = (phase == MP_LO) ? prod : {prod[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MP_CROSS_B) && !start;
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
    end
    if (phase == MP_LO) begin
      acc <= addend;
    end else if (phase != MP_IDLE) begin
      acc <= acc + addend;
    end
  end

endmodule

@@ hw/rtl/mh_back.sv @@
// ----------------------------------------------------------------------------
// mh_back
// Sequencer that runs each queued item through the shared 64-bit multiply:
// seed load, key mix, hash update, tail, finalize, and the result register.
// ----------------------------------------------------------------------------
module mh_back
  import mh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  item_t     q_head,
  output logic      pop,
  mh_hash_if.source res
);

  back_state_t state;
  back_state_t state_next;
  back_state_t disp_state;
  item_t       cur;
  logic [63:0] h;
  logic [31:0] fin;
  logic        out_valid;
  logic [31:0] out_hash;
  logic [63:0] h_src;
  logic [63:0] disp_a;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        can_emit;

  mh_mul64 u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .done   (mul_done),
    .result (mul_res)
  );

  assign res.valid      = out_valid;
  assign res.hash_value = out_hash;
  assign can_emit       = !out_valid || res.ready;

  // hash entering the word step, freshly seeded on a message's first word
  assign h_src = (state == BS_LEN) ? ({32'd0, cur.seed} ^ mul_res) : h;

  // first multiply of the word step
  always_comb begin
    disp_a     = cur.word;
    disp_state = BS_KEY1;
    case (cur.kind)
      OP_FULL: begin
        disp_a     = cur.word;
        disp_state = BS_KEY1;
      end
      OP_TAIL: begin
        disp_a     = h_src ^ (cur.word & tail_mask(cur.tail_bytes));
        disp_state = BS_HASH;
      end
      default: begin
        disp_a     = xs47(h_src);
        disp_state = BS_FIN;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: if (!q_empty) state_next = BS_DISP;
      BS_DISP: state_next = cur.first ? BS_LEN : disp_state;
      BS_LEN:  if (mul_done) state_next = disp_state;
      BS_KEY1: if (mul_done) state_next = BS_KEY2;
      BS_KEY2: if (mul_done) state_next = BS_HASH;
      BS_HASH: if (mul_done) state_next = cur.last ? BS_FIN : BS_IDLE;
      BS_FIN:  if (mul_done) state_next = BS_EMIT;
      BS_EMIT: if (can_emit) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  // outputs: queue pop and multiply launches
  always_comb begin
    pop       = 1'b0;
    mul_start = 1'b0;
    mul_a     = disp_a;
    unique case (state)
      BS_IDLE: pop = !q_empty;
      BS_DISP: begin
        mul_start = 1'b1;
        mul_a     = cur.first ? {32'd0, cur.len} : disp_a;
      end
      BS_LEN: begin
        mul_start = mul_done;
        mul_a     = disp_a;
      end
      BS_KEY1: begin
        mul_start = mul_done;
        mul_a     = xs47(mul_res);
      end
      BS_KEY2: begin
        mul_start = mul_done;
        mul_a     = h ^ mul_res;
      end
      BS_HASH: begin
        mul_start = mul_done && cur.last;
        mul_a     = xs47(mul_res);
      end
      BS_FIN:  mul_start = 1'b0;
      BS_EMIT: mul_start = 1'b0;
      default: mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // current item, running hash and finalized value
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (state == BS_LEN && mul_done) begin
      h <= h_src;
    end else if (state == BS_HASH && mul_done) begin
      h <= mul_res;
    end
    if (state == BS_FIN && mul_done) begin
      fin <= 32'(xs47(mul_res));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BS_EMIT && can_emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_EMIT && can_emit) begin
      out_hash <= fin;
    end
  end

endmodule

@@ hw/rtl/murmur64a_stream_hash_core.sv @@
// ----------------------------------------------------------------------------
// murmur64a_stream_hash_core
// MurmurHash64A over little-endian 64-bit message words.
//
// msg carries one word per item with byte_count and last; seed and
// total_length are taken from the first word of each message. res carries
// the low 32 bits of the finalized hash, one item per message.
// A front stage classifies words into a two-entry queue; the back end runs
// them through one 32x32 multiplier, three partial products per 64-bit
// multiply. Multiplies per word in the back end:
//   full word: key, key after xor-shift, hash update; tail word: hash update
//   after the tail xor; zero-byte last word: none of these;
//   plus the length multiply on the first word of a message (seed load),
//   plus the finalize multiply and result hand-off on the last word.
// The hash-chain multiply sets the rate; the result is registered from EMIT.
// Reset (rst, synchronous) empties the queue and result register and makes
// the next word the first of a message. While res is stalled the finished
// hash waits in its register, and the queue and the back end keep working
// on the next message until its own result is ready.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash_core
  import mh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mh_msg_if.sink    msg,
  mh_hash_if.source res
);

  push_t push;
  item_t q_head;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  mh_front u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_full (q_full),
    .push   (push)
  );

  mh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  mh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .res     (res)
  );

endmodule

@@ hw/rtl/mh_check.sv @@
// ----------------------------------------------------------------------------
// mh_check
// Port-level checks of the hash core: result handshake, reset behavior and
// that every result belongs to a delivered last word.
// ----------------------------------------------------------------------------
module mh_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);

  logic [2:0] pending;
  logic       last_in;
  logic       hash_out;

  assign last_in  = in_valid && in_ready && in_last;
  assign hash_out = out_valid && out_ready;

  // messages closed but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !hash_out) begin
      pending <= pending + 1'b1;
    end else if (hash_out && !last_in) begin
      pending <= pending - 1'b1;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("stalled hash changed or dropped");

  // reset clears the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // every result answers a closed message
  a_owned: assert property (@(posedge clk) disable iff (rst)
    hash_out |-> pending != 3'd0)
    else $error("hash without a last word");

  // queue, back end and result register bound the open messages
  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("too many unanswered messages");

endmodule

bind murmur64a_stream_hash_core mh_check u_mh_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_last   (msg.last),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_hash  (res.hash_value)
);
